### rtl/assert_macros.svh
// Assertion helpers used by fct_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fct assertion failed");
`define FCT_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("fct forbidden condition seen");
`else
`define FCT_ASSERT(lbl, clk, rstn, prop)
`define FCT_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

### rtl/fct_pkg.sv
package fct_pkg;

  localparam int unsigned CL_W   = 12;
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned BA_W   = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CMP_W  = 14;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_GET  = 3'd2;
  localparam logic [2:0] OP_SET  = 3'd3;
  localparam logic [2:0] OP_FIND = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd2;

  localparam logic [CL_W-1:0] SCAN_FIRST = 12'h002;
  localparam logic [CL_W-1:0] SCAN_END   = 12'hFF0;
  localparam logic [CL_W-1:0] EOF_RESET  = 12'hFFF;

  typedef enum logic [2:0] {
    K_LOAD,
    K_READ,
    K_GET,
    K_SET,
    K_FIND,
    K_NONE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CL_W-1:0]   cluster;
    logic [CL_W-1:0]   next_cluster;
    logic [OFF_W-1:0]  addr;
    logic [BYTE_W-1:0] byte_in;
    logic              in_range;
  } cmd_t;

endpackage

### rtl/fct_front.sv
module fct_front #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,
  input  logic [2:0]    s_axis_tuser,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output fct_pkg::cmd_t cmd_o
);

  localparam logic [fct_pkg::CMP_W-1:0] TB = fct_pkg::CMP_W'(TABLE_BYTES);

  logic [fct_pkg::CL_W-1:0]   cluster;
  logic [fct_pkg::CL_W-1:0]   eff_cluster;
  logic [fct_pkg::OFF_W-1:0]  offset;
  logic [fct_pkg::BA_W-1:0]   byte_addr;
  logic [fct_pkg::CMP_W-1:0]  entry_end;
  fct_pkg::cmd_t              cmd_d;
  fct_pkg::cmd_t              cmd_q;
  logic                       valid_q;

  assign cluster   = s_axis_tdata[11:0];
  assign byte_addr = s_axis_tdata[33:24];

  always_comb begin
    cmd_d              = '0;
    cmd_d.next_cluster = s_axis_tdata[23:12];
    cmd_d.byte_in      = s_axis_tdata[41:34];
    unique case (s_axis_tuser)
      fct_pkg::OP_LOAD: cmd_d.kind = fct_pkg::K_LOAD;
      fct_pkg::OP_READ: cmd_d.kind = fct_pkg::K_READ;
      fct_pkg::OP_GET:  cmd_d.kind = fct_pkg::K_GET;
      fct_pkg::OP_SET:  cmd_d.kind = fct_pkg::K_SET;
      fct_pkg::OP_FIND: cmd_d.kind = fct_pkg::K_FIND;
      default:          cmd_d.kind = fct_pkg::K_NONE;
    endcase
    eff_cluster = (cmd_d.kind == fct_pkg::K_FIND) ? fct_pkg::SCAN_FIRST : cluster;
    offset      = {1'b0, eff_cluster} + {2'b00, eff_cluster[fct_pkg::CL_W-1:1]};
    entry_end   = {1'b0, offset} + 14'd1;
    cmd_d.cluster = eff_cluster;
    if (cmd_d.kind == fct_pkg::K_LOAD || cmd_d.kind == fct_pkg::K_READ) begin
      cmd_d.addr     = {3'b000, byte_addr};
      cmd_d.in_range = {4'b0000, byte_addr} < TB;
    end else begin
      cmd_d.addr     = offset;
      cmd_d.in_range = entry_end < TB;
    end
  end

  assign s_axis_tready = !valid_q || cmd_ready_i;
  assign cmd_valid_o   = valid_q;
  assign cmd_o         = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### rtl/fct_queue.sv
module fct_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fct_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fct_pkg::cmd_t pop_cmd_o
);

  fct_pkg::cmd_t ent_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_cmd_o    = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/fct_back.sv
`include "assert_macros.svh"

module fct_back #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fct_pkg::CL_W-1:0]   eof_marker_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  fct_pkg::cmd_t              cmd_i,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,
  output logic [1:0]                 m_axis_tuser
);

  localparam int unsigned AW = $clog2(TABLE_BYTES);
  localparam logic [fct_pkg::CMP_W-1:0] TB = fct_pkg::CMP_W'(TABLE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_LO,
    S_HI,
    S_WHI
  } state_e;

  state_e                       state_q;
  fct_pkg::kind_e               kind_q;
  logic [fct_pkg::CL_W-1:0]     cluster_q;
  logic [fct_pkg::CL_W-1:0]     next_q;
  logic [fct_pkg::OFF_W-1:0]    off_q;
  logic [fct_pkg::BYTE_W-1:0]   lo_q;
  logic [fct_pkg::BYTE_W-1:0]   hi_new_q;
  logic                         out_valid_q;
  logic [fct_pkg::CL_W-1:0]     out_entry_q;
  logic [fct_pkg::BYTE_W-1:0]   out_byte_q;
  logic [fct_pkg::ST_W-1:0]     out_status_q;

  logic [fct_pkg::BYTE_W-1:0]   tbl_q [TABLE_BYTES];
  logic [fct_pkg::BYTE_W-1:0]   rdata_q;

  logic                         out_free;
  logic                         pop;
  logic [fct_pkg::BYTE_W-1:0]   hi;
  logic [fct_pkg::CL_W-1:0]     entry;
  logic [fct_pkg::BYTE_W-1:0]   lo_new;
  logic [fct_pkg::BYTE_W-1:0]   hi_new;
  logic [fct_pkg::CL_W-1:0]     c_nx;
  logic [fct_pkg::OFF_W-1:0]    off_nx;
  logic                         scan_end;
  logic                         re;
  logic                         we;
  logic [fct_pkg::OFF_W-1:0]    raddr;
  logic [fct_pkg::OFF_W-1:0]    waddr;
  logic [fct_pkg::BYTE_W-1:0]   wdata;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign hi     = rdata_q;
  assign entry  = cluster_q[0] ? {hi, lo_q[7:4]} : {hi[3:0], lo_q};
  assign lo_new = cluster_q[0] ? {next_q[3:0], lo_q[3:0]} : next_q[7:0];
  assign hi_new = cluster_q[0] ? next_q[11:4] : {hi[7:4], next_q[11:8]};
  assign c_nx   = cluster_q + 12'd1;
  assign off_nx = off_q + (cluster_q[0] ? 13'd2 : 13'd1);
  assign scan_end = (c_nx == fct_pkg::SCAN_END) || (({1'b0, off_nx} + 14'd1) >= TB);

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = off_q;
    waddr = off_q;
    wdata = lo_new;
    unique case (state_q)
      S_IDLE: begin
        raddr = cmd_i.addr;
        waddr = cmd_i.addr;
        wdata = cmd_i.byte_in;
        if (pop && cmd_i.in_range) begin
          we = cmd_i.kind == fct_pkg::K_LOAD;
          re = cmd_i.kind == fct_pkg::K_READ || cmd_i.kind == fct_pkg::K_GET ||
               cmd_i.kind == fct_pkg::K_SET || cmd_i.kind == fct_pkg::K_FIND;
        end
      end
      S_LO: begin
        re    = 1'b1;
        raddr = off_q + 13'd1;
      end
      S_HI: begin
        we    = kind_q == fct_pkg::K_SET;
        raddr = off_nx;
        re    = kind_q == fct_pkg::K_FIND && entry != '0 && !scan_end;
      end
      S_WHI: begin
        we    = 1'b1;
        waddr = off_q + 13'd1;
        wdata = hi_new_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      tbl_q[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= tbl_q[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= fct_pkg::K_NONE;
      cluster_q    <= '0;
      next_q       <= '0;
      off_q        <= '0;
      lo_q         <= '0;
      hi_new_q     <= '0;
      out_valid_q  <= 1'b0;
      out_entry_q  <= '0;
      out_byte_q   <= '0;
      out_status_q <= fct_pkg::ST_OK;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            kind_q    <= cmd_i.kind;
            cluster_q <= cmd_i.cluster;
            next_q    <= cmd_i.next_cluster;
            off_q     <= cmd_i.addr;
            out_entry_q  <= '0;
            out_byte_q   <= '0;
            out_status_q <= fct_pkg::ST_OK;
            unique case (cmd_i.kind)
              fct_pkg::K_LOAD: begin
                out_valid_q <= 1'b1;
                if (!cmd_i.in_range) begin
                  out_status_q <= fct_pkg::ST_RANGE;
                end
              end
              fct_pkg::K_READ: begin
                if (cmd_i.in_range) begin
                  state_q <= S_BYTE;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= fct_pkg::ST_RANGE;
                end
              end
              fct_pkg::K_GET, fct_pkg::K_SET: begin
                if (cmd_i.in_range) begin
                  state_q <= S_LO;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_entry_q  <= eof_marker_i;
                  out_status_q <= fct_pkg::ST_RANGE;
                end
              end
              fct_pkg::K_FIND: begin
                if (cmd_i.in_range) begin
                  state_q <= S_LO;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_entry_q  <= eof_marker_i;
                  out_status_q <= fct_pkg::ST_NOFREE;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_BYTE: begin
          out_valid_q <= 1'b1;
          out_byte_q  <= rdata_q;
          state_q     <= S_IDLE;
        end
        S_LO: begin
          lo_q    <= rdata_q;
          state_q <= S_HI;
        end
        S_HI: begin
          unique case (kind_q)
            fct_pkg::K_GET: begin
              out_valid_q <= 1'b1;
              out_entry_q <= entry;
              state_q     <= S_IDLE;
            end
            fct_pkg::K_SET: begin
              hi_new_q <= hi_new;
              state_q  <= S_WHI;
            end
            default: begin
              if (entry == '0) begin
                out_valid_q <= 1'b1;
                out_entry_q <= cluster_q;
                state_q     <= S_IDLE;
              end else if (scan_end) begin
                out_valid_q  <= 1'b1;
                out_entry_q  <= eof_marker_i;
                out_status_q <= fct_pkg::ST_NOFREE;
                state_q      <= S_IDLE;
              end else begin
                cluster_q <= c_nx;
                off_q     <= off_nx;
                state_q   <= S_LO;
              end
            end
          endcase
        end
        S_WHI: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_byte_q, out_entry_q};
  assign m_axis_tuser  = out_status_q;

  `FCT_ASSERT(a_busy_out_empty, clk_i, rst_ni, state_q != S_IDLE |-> !out_valid_q)
  `FCT_ASSERT(a_scan_window, clk_i, rst_ni,
      (state_q == S_HI && kind_q == fct_pkg::K_FIND) |->
      (cluster_q >= fct_pkg::SCAN_FIRST && cluster_q < fct_pkg::SCAN_END))
  `FCT_ASSERT(a_write_in_table, clk_i, rst_ni, we |-> ({1'b0, waddr} < TB))
  `FCT_ASSERT_NEVER(a_read_past_end, clk_i, rst_ni, re && ({1'b0, raddr} >= TB))

endmodule

### rtl/fat12_cluster_table_engine.sv
// FAT12 allocation table engine over a single-port byte memory of TABLE_BYTES
// bytes. Requests enter through a one-entry front stage and a two-entry queue,
// and the back sequencer serves one request at a time; its cost is set by the
// single table port, one byte access per cycle with registered read data.
// Load byte writes one byte, read byte reads one, get next reads the low and
// high bytes of the entry, set next reads both and writes both back, and find
// free reads two bytes per cluster examined until it meets a free entry or the
// end of the scan. Requests out of range finish without a table access. The
// table holds no reset value: every byte must be loaded before it is read.
module fat12_cluster_table_engine #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,     // eof_marker
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,    // cluster, next_cluster, byte_addr, byte_in
  input  logic [2:0]  s_axis_tuser,    // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // entry_value, byte_out
  output logic [1:0]  m_axis_tuser     // status
);

  logic [fct_pkg::CL_W-1:0] eof_q;
  logic                     f_valid;
  logic                     f_ready;
  fct_pkg::cmd_t            f_cmd;
  logic                     q_valid;
  logic                     q_ready;
  fct_pkg::cmd_t            q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eof_q <= fct_pkg::EOF_RESET;
    end else if (cfg_we_i) begin
      eof_q <= cfg_wdata_i;
    end
  end

  fct_front #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd)
  );

  fct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_cmd_i  (f_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_cmd_o   (q_cmd)
  );

  fct_back #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eof_marker_i (eof_q),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_BYTES = 1024;
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
  localparam logic [fct_pkg::CL_W-1:0] CL_LAST_FIT  = 12'd681;
  localparam logic [fct_pkg::CL_W-1:0] CL_FIRST_OUT = 12'd682;
  localparam int unsigned ITEMS_PER_PHASE = 10;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [fct_pkg::CL_W-1:0]   entry;
    logic [fct_pkg::BYTE_W-1:0] bout;
    logic [fct_pkg::ST_W-1:0]   status;
  } fat_result_t;

  class fat_scoreboard;
    logic [fct_pkg::BYTE_W-1:0] tbl [TBL_BYTES];
    logic [fct_pkg::CL_W-1:0]   eof_marker;
    fat_result_t                expected_q [$];
    int                         errors;

    function new();
      eof_marker = fct_pkg::EOF_RESET;
      errors = 0;
      foreach (tbl[i]) tbl[i] = '0;
    endfunction

    function logic [fct_pkg::OFF_W-1:0] offset_of(logic [fct_pkg::CL_W-1:0] cl);
      return {1'b0, cl} + {2'b0, cl[fct_pkg::CL_W-1:1]};
    endfunction

    function bit fits(logic [fct_pkg::CL_W-1:0] cl);
      return int'(offset_of(cl)) + 1 < TBL_BYTES;
    endfunction

    function logic [fct_pkg::CL_W-1:0] entry_of(logic [fct_pkg::CL_W-1:0] cl);
      logic [fct_pkg::OFF_W-1:0] off;
      logic [15:0]               word;
      off = offset_of(cl);
      word = {tbl[off + 1], tbl[off]};
      return cl[0] ? word[15:4] : word[11:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [2:0] op, logic [fct_pkg::CL_W-1:0] cl,
                               logic [fct_pkg::CL_W-1:0] nx,
                               logic [fct_pkg::BA_W-1:0] ba,
                               logic [fct_pkg::BYTE_W-1:0] bi);
      fat_result_t               r;
      logic [fct_pkg::OFF_W-1:0] off;
      logic [15:0]               word;
      int                        c;
      bit                        found;
      r = '0;
      case (op)
        fct_pkg::OP_LOAD: begin
          if (ba < TBL_BYTES) tbl[ba] = bi;
          else r.status = fct_pkg::ST_RANGE;
        end
        fct_pkg::OP_READ: begin
          if (ba < TBL_BYTES) r.bout = tbl[ba];
          else r.status = fct_pkg::ST_RANGE;
        end
        fct_pkg::OP_GET: begin
          if (fits(cl)) begin
            r.entry = entry_of(cl);
          end else begin
            r.entry = eof_marker;
            r.status = fct_pkg::ST_RANGE;
          end
        end
        fct_pkg::OP_SET: begin
          if (fits(cl)) begin
            off = offset_of(cl);
            word = {tbl[off + 1], tbl[off]};
            if (cl[0]) word = {nx, word[3:0]};
            else word = {word[15:12], nx};
            tbl[off] = word[7:0];
            tbl[off + 1] = word[15:8];
          end else begin
            r.entry = eof_marker;
            r.status = fct_pkg::ST_RANGE;
          end
        end
        fct_pkg::OP_FIND: begin
          found = 1'b0;
          for (c = fct_pkg::SCAN_FIRST; c < fct_pkg::SCAN_END; c++) begin
            if (!fits(c[fct_pkg::CL_W-1:0])) break;
            if (entry_of(c[fct_pkg::CL_W-1:0]) == '0) begin
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            r.entry = c[fct_pkg::CL_W-1:0];
          end else begin
            r.entry = eof_marker;
            r.status = fct_pkg::ST_NOFREE;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [fct_pkg::CL_W-1:0] ev, logic [fct_pkg::BYTE_W-1:0] bo,
                               logic [fct_pkg::ST_W-1:0] st, logic [3:0] pad);
      fat_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request pending: entry %h byte %h status %0d",
                 $time, ev, bo, st);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (ev !== want.entry) begin
        $display("%0t: entry_value expected %h actual %h", $time, want.entry, ev);
        errors++;
      end
      if (bo !== want.bout) begin
        $display("%0t: byte_out expected %h actual %h", $time, want.bout, bo);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (pad !== 4'h0) begin
        $display("%0t: tdata padding expected 0 actual %h", $time, pad);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  fat_scoreboard sb = new();

  fat12_cluster_table_engine #(
    .TABLE_BYTES(TBL_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tuser,
                      m_axis_tdata[23:20]);
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[fat12_cluster_table_engine] ERROR");
    $finish;
  end

  task automatic send_req(input logic [2:0] op, input logic [fct_pkg::CL_W-1:0] cl,
                          input logic [fct_pkg::CL_W-1:0] nx,
                          input logic [fct_pkg::BA_W-1:0] ba,
                          input logic [fct_pkg::BYTE_W-1:0] bi);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, bi, ba, nx, cl};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, cl, nx, ba, bi);
  endtask

  task automatic tx_pause(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_eof(input logic [fct_pkg::CL_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.eof_marker = v;
  endtask

  task automatic send_random_item();
    int unsigned                pick;
    logic [2:0]                 op;
    logic [fct_pkg::CL_W-1:0]   cl;
    logic [fct_pkg::CL_W-1:0]   nx;
    logic [fct_pkg::BA_W-1:0]   ba;
    logic [fct_pkg::BYTE_W-1:0] bi;
    if (tx_idle_en && $urandom_range(0, 7) == 0) tx_pause($urandom_range(1, 19));
    pick = $urandom_range(0, 99);
    if (pick < 25) op = fct_pkg::OP_LOAD;
    else if (pick < 40) op = fct_pkg::OP_READ;
    else if (pick < 65) op = fct_pkg::OP_GET;
    else if (pick < 90) op = fct_pkg::OP_SET;
    else if (pick < 96) op = fct_pkg::OP_FIND;
    else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    cl = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, CL_FIRST_OUT)) : 12'($urandom);
    nx = ($urandom_range(0, 3) == 0) ? '0 : 12'($urandom);
    ba = 10'($urandom);
    bi = 8'($urandom);
    send_req(op, cl, nx, ba, bi);
  endtask

  initial begin
    logic [fct_pkg::CL_W-1:0] phase_eof [4];
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= fct_pkg::OP_LOAD;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every byte is nonzero after the fill, so no entry is free yet.
    for (int i = 0; i < TBL_BYTES; i++) begin
      send_req(fct_pkg::OP_LOAD, 12'($urandom), 12'($urandom), 10'(i),
               8'($urandom_range(1, 255)));
    end

    send_req(fct_pkg::OP_FIND, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_READ, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_READ, 12'hFFF, 12'hFFF, 10'd1023, 8'hFF);
    send_req(fct_pkg::OP_GET, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, 12'h001, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, CL_LAST_FIT, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, CL_FIRST_OUT, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, 12'hFFF, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_SET, CL_FIRST_OUT, 12'hFFF, 10'd0, 8'h00);
    send_req(fct_pkg::OP_SET, 12'hFFF, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_SET, CL_LAST_FIT, 12'hFFF, 10'd0, 8'h00);
    send_req(fct_pkg::OP_SET, CL_LAST_FIT - 12'd1, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, CL_LAST_FIT - 12'd1, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, CL_LAST_FIT, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_FIND, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_LOAD, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_LOAD, 12'hFFF, 12'hFFF, 10'd1023, 8'hFF);
    send_req(fct_pkg::OP_READ, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_READ, 12'h000, 12'h000, 10'd1023, 8'h00);
    send_req(OP_RSVD_FIRST, 12'hFFF, 12'hFFF, 10'd1023, 8'hFF);
    send_req(OP_RSVD_FIRST + 3'd1, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(OP_RSVD_LAST, 12'hABC, 12'h123, 10'd512, 8'h5A);
    drain();

    write_eof(12'h000);
    send_req(fct_pkg::OP_SET, CL_LAST_FIT - 12'd1, 12'h001, 10'd0, 8'h00);
    send_req(fct_pkg::OP_FIND, 12'h000, 12'h000, 10'd0, 8'h00);
    send_req(fct_pkg::OP_GET, CL_FIRST_OUT, 12'h000, 10'd0, 8'h00);
    drain();

    phase_eof[0] = 12'($urandom);
    phase_eof[1] = 12'hFFF;
    phase_eof[2] = 12'h000;
    phase_eof[3] = 12'($urandom);
    for (int p = 0; p < 4; p++) begin
      write_eof(phase_eof[p]);
      if (p == 3) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random_item();
      drain();
    end

    if (sb.errors == 0) begin
      $display("[fat12_cluster_table_engine] OK");
    end else begin
      $display("[fat12_cluster_table_engine] ERROR");
    end
    $finish;
  end

endmodule
